// ----- rtl/svmk_pkg.sv -----
// ----------------------------------------------------------------------------
// svmk_pkg
// Shared types and constants of the SVM kernel evaluator.
// ----------------------------------------------------------------------------
package svmk_pkg;

  localparam int ELEM_W = 16;
  localparam int ACC_W  = 48;

  localparam logic [1:0] KIND_LINEAR = 2'd0;
  localparam logic [1:0] KIND_POLY   = 2'd1;

  localparam logic [1:0] CFG_KIND   = 2'd0;
  localparam logic [1:0] CFG_DEGREE = 2'd1;
  localparam logic [1:0] CFG_COEFF  = 2'd2;

  localparam logic [31:0] POW_CAP   = 32'h8000_0001;
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;

  typedef enum logic [2:0] {
    ST_ACC,
    ST_POW,
    ST_G1,
    ST_G2,
    ST_G3,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic acc_en;    // accumulate the accepted pair
    logic fin;       // latch final values from the accumulator
    logic pow_step;  // one polynomial multiply
    logic g1;        // gauss: t
    logic g2;        // gauss: u
    logic g3;        // gauss: interpolate and shift
  } cmd_t;

  function automatic logic [16:0] exp2_tab(input logic [4:0] j);
    case (j)
      5'd0:  exp2_tab = 17'd65536;
      5'd1:  exp2_tab = 17'd62757;
      5'd2:  exp2_tab = 17'd60097;
      5'd3:  exp2_tab = 17'd57549;
      5'd4:  exp2_tab = 17'd55109;
      5'd5:  exp2_tab = 17'd52773;
      5'd6:  exp2_tab = 17'd50535;
      5'd7:  exp2_tab = 17'd48393;
      5'd8:  exp2_tab = 17'd46341;
      5'd9:  exp2_tab = 17'd44376;
      5'd10: exp2_tab = 17'd42495;
      5'd11: exp2_tab = 17'd40693;
      5'd12: exp2_tab = 17'd38968;
      5'd13: exp2_tab = 17'd37316;
      5'd14: exp2_tab = 17'd35734;
      5'd15: exp2_tab = 17'd34219;
      default: exp2_tab = 17'd32768;
    endcase
  endfunction

endpackage

// ----- rtl/svmk_ctrl.sv -----
// ----------------------------------------------------------------------------
// svmk_ctrl
// Sequencer: accumulation, polynomial power loop, gauss steps, result hold.
// ----------------------------------------------------------------------------
module svmk_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_last,
  input  logic [1:0]         kind,
  input  logic [3:0]         degree,
  input  logic               out_ready,
  output logic               in_ready,
  output logic               out_valid,
  output svmk_pkg::cmd_t     cmd
);
  import svmk_pkg::*;

  state_t     state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_ACC;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_ACC: begin
        in_ready   = 1'b1;
        cmd.acc_en = in_valid;
        if (in_valid && in_last) begin
          cmd.fin = 1'b1;
          if (kind[1]) begin
            state_nxt = ST_G1;
          end else if (kind == KIND_POLY && degree != 4'd0) begin
            cnt_nxt   = degree;
            state_nxt = ST_POW;
          end else begin
            state_nxt = ST_OUT;
          end
        end
      end
      ST_POW: begin
        cmd.pow_step = 1'b1;
        cnt_nxt      = cnt_r - 4'd1;
        if (cnt_r == 4'd1) begin
          state_nxt = ST_OUT;
        end
      end
      ST_G1: begin
        cmd.g1    = 1'b1;
        state_nxt = ST_G2;
      end
      ST_G2: begin
        cmd.g2    = 1'b1;
        state_nxt = ST_G3;
      end
      ST_G3: begin
        cmd.g3    = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = ST_ACC;
        end
      end
      default: state_nxt = ST_ACC;
    endcase
  end
endmodule

// ----- rtl/svmk_dp.sv -----
// ----------------------------------------------------------------------------
// svmk_dp
// Datapath: saturating accumulator, power multiplier, gauss exponent unit.
// ----------------------------------------------------------------------------
module svmk_dp (
  input  logic                           clk,
  input  svmk_pkg::cmd_t                 cmd,
  input  logic                           rst_n,
  input  logic signed [svmk_pkg::ELEM_W-1:0] x_elem,
  input  logic signed [svmk_pkg::ELEM_W-1:0] y_elem,
  input  logic [1:0]                     kind,
  input  logic [23:0]                    coeff,
  output logic signed [31:0]             kernel_value,
  output logic                           saturated
);
  import svmk_pkg::*;

  localparam logic signed [ACC_W-1:0] AMAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] AMIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [ACC_W+1:0] SMAX = {2'b00, AMAX};
  localparam logic signed [ACC_W+1:0] SMIN = {2'b11, AMIN};

  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic [ACC_W-1:0]        dist_r;
  logic [31:0]             base_r, m_r;
  logic                    neg_r, odd_r, kpoly_r;
  logic signed [31:0]      val_r, val_nxt;
  logic                    sat_r, sat_nxt;
  logic [31:0]             t_r;
  logic [31:0]             u_r;
  logic                    zero_r;

  // Accumulation term.
  logic signed [ELEM_W:0]     diff;
  logic signed [2*ELEM_W+1:0] term;
  logic signed [ACC_W+1:0]    sum;
  always_comb begin
    diff = {x_elem[ELEM_W-1], x_elem} - {y_elem[ELEM_W-1], y_elem};
    if (kind[1]) term = diff * diff;
    else         term = x_elem * y_elem;
    sum = {{2{acc_r[ACC_W-1]}}, acc_r} + {{(ACC_W-2*ELEM_W){term[2*ELEM_W+1]}}, term};
    if (sum > SMAX)      acc_nxt = AMAX;
    else if (sum < SMIN) acc_nxt = AMIN;
    else                 acc_nxt = sum[ACC_W-1:0];
  end

  // Rounded Q16.16 dot product of the final accumulator.
  logic signed [ACC_W-8:0] dq;
  logic signed [ACC_W-7:0] base;
  logic [ACC_W-7:0]        bmag;
  always_comb begin
    dq   = {acc_nxt[ACC_W-1], acc_nxt[ACC_W-1:8]} + (ACC_W-7)'(acc_nxt[7]);
    base = {dq[ACC_W-8], dq} + (ACC_W-6)'(65536);
    bmag = base[ACC_W-7] ? -base : base;
  end

  // One power step.
  logic [63:0] prod;
  logic [48:0] mq;
  always_comb begin
    prod = m_r * base_r;
    mq   = 49'((prod + 64'd32768) >> 16);
  end

  // Gauss pieces.
  logic [48:0] tfull;
  logic [48:0] ufull;
  logic [15:0] f;
  logic [3:0]  j;
  logic [16:0] e0, e1;
  logic [28:0] ip;
  logic [16:0] mg;
  logic [15:0] n;
  logic [57:0] shv;
  always_comb begin
    tfull = 49'((coeff * dist_r[47:24]) + ((coeff * dist_r[23:0]) >> 24));
    ufull = 49'((t_r * LOG2E_Q16) >> 16);
    f     = u_r[15:0];
    n     = u_r[31:16];
    j     = f[15:12];
    e0    = exp2_tab({1'b0, j});
    e1    = exp2_tab({1'b0, j} + 5'd1);
    ip    = 29'((e0 - e1) * f[11:0]) + 29'd2048;
    mg    = e0 - 17'(ip >> 12);
    shv   = 58'(({41'd0, mg} + ((n == 0) ? 58'd0 : (58'd1 << (n - 16'd1)))) >> n);
  end

  always_comb begin
    val_nxt = val_r;
    sat_nxt = sat_r;
    if (cmd.fin) begin
      sat_nxt = 1'b0;
      if (dq > 41'sh7FFF_FFFF) begin
        val_nxt = 32'sh7FFF_FFFF;
        sat_nxt = (kind == KIND_LINEAR);
      end else if (dq < -41'sh8000_0000) begin
        val_nxt = 32'sh8000_0000;
        sat_nxt = (kind == KIND_LINEAR);
      end else begin
        val_nxt = dq[31:0];
      end
      if (kind == KIND_POLY) begin
        val_nxt = 32'sd65536; // degree zero
        sat_nxt = 1'b0;
      end
    end else if (cmd.g3) begin
      sat_nxt = 1'b0;
      if (zero_r || n > 16'd40) val_nxt = '0;
      else                      val_nxt = shv[31:0];
    end
  end

  // Saturation of the power step result; its sign is applied at the output.
  logic [31:0] mres;
  assign mres = (mq > {17'd0, POW_CAP}) ? POW_CAP : mq[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (cmd.acc_en) begin
      acc_r <= cmd.fin ? '0 : acc_nxt;
    end
    if (cmd.fin) begin
      dist_r  <= acc_nxt[ACC_W-1] ? '0 : acc_nxt;
      base_r  <= (bmag > (ACC_W-6)'(POW_CAP)) ? POW_CAP : bmag[31:0];
      neg_r   <= base[ACC_W-7];
      kpoly_r <= (kind == KIND_POLY);
      m_r     <= 32'd65536;
    end
    if (cmd.pow_step) m_r <= mres;
    if (cmd.fin || cmd.pow_step) odd_r <= cmd.fin ? 1'b0 : ~odd_r;
    if (cmd.g1) begin
      zero_r <= (tfull >= 49'(12 * 65536));
      t_r    <= tfull[31:0];
    end
    if (cmd.g2) u_r <= ufull[31:0];
    val_r <= val_nxt;
    sat_r <= sat_nxt;
  end

  always_comb begin
    kernel_value = val_r;
    saturated    = sat_r;
    if (kpoly_r) begin
      saturated = 1'b0;
      if (neg_r && odd_r) begin
        if (m_r > 32'h8000_0000) begin
          kernel_value = 32'sh8000_0000;
          saturated    = 1'b1;
        end else begin
          kernel_value = -m_r;
        end
      end else if (m_r > 32'h7FFF_FFFF) begin
        kernel_value = 32'sh7FFF_FFFF;
        saturated    = 1'b1;
      end else begin
        kernel_value = m_r;
      end
    end
  end
endmodule

// ----- rtl/svm_kernel_evaluator_unit.sv -----
// ----------------------------------------------------------------------------
// svm_kernel_evaluator_unit
// SVM kernel (linear, polynomial, gauss) over a stream of element pairs.
// ----------------------------------------------------------------------------
// Element pairs are taken one per cycle while a vector streams in. After the
// last pair the block stops taking input until its result is delivered. The
// result is offered in the cycle after the last pair for the linear kernel and
// for a polynomial of degree zero, after one multiply per degree on the power
// multiplier for the polynomial kernel, and after three exponent steps (t, u,
// then interpolate and shift) for gauss.
// A stalled result holds off the next vector for as long as the stall lasts.
module svm_kernel_evaluator_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [15:0]  in_x_elem,
  input  logic signed [15:0]  in_y_elem,
  input  logic                in_last_elem,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  out_kernel_value,
  output logic                out_saturated,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [23:0]         cfg_data
);
  import svmk_pkg::*;

  logic [1:0]  kind_r;
  logic [3:0]  degree_r;
  logic [23:0] coeff_r;
  cmd_t        cmd;
  cmd_t        cmd_g;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r   <= 2'd2;
      degree_r <= 4'd2;
      coeff_r  <= 24'd32768;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KIND:   kind_r   <= cfg_data[1:0];
        CFG_DEGREE: degree_r <= cfg_data[3:0];
        CFG_COEFF:  coeff_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  svmk_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_last(in_last_elem),
    .kind(kind_r), .degree(degree_r), .out_ready(out_ready),
    .in_ready(in_ready), .out_valid(out_valid), .cmd(cmd)
  );

  assign cmd_g = cmd;

  svmk_dp u_dp (
    .clk(clk), .cmd(cmd_g), .rst_n(rst_n), .x_elem(in_x_elem), .y_elem(in_y_elem),
    .kind(kind_r), .coeff(coeff_r), .kernel_value(out_kernel_value),
    .saturated(out_saturated)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input and result both open");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_last_stops: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last_elem |=> !in_ready) else $error("took item after last");
endmodule
